/* rtl/xcrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package xcrc_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 128;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam logic [7:0]  HDR_SOH   = 8'h01;
  localparam logic [7:0]  HDR_EOT   = 8'h04;
  localparam logic [7:0]  REPLY_ACK = 8'h06;
  localparam logic [7:0]  REPLY_NAK = 8'h15;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_TOP   = 16'h8000;

  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } command_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_EOT     = 3'd2,
    ST_BADCOMP = 3'd3,
    ST_DUP     = 3'd4,
    ST_UNEXP   = 3'd5,
    ST_BADCRC  = 3'd6,
    ST_BADHDR  = 3'd7
  } status_t;

  // what the first byte of the packet was
  typedef enum logic [1:0] {
    HDR_CLASS_OTHER = 2'd0,
    HDR_CLASS_SOH   = 2'd1,
    HDR_CLASS_EOT   = 2'd2
  } hdr_class_t;

  // work handed from the front to the back
  typedef enum logic [2:0] {
    OP_NUMBER     = 3'd0,
    OP_COMPLEMENT = 3'd1,
    OP_PAYLOAD    = 3'd2,
    OP_CRC_HIGH   = 3'd3,
    OP_CRC_LOW    = 3'd4,
    OP_TIMEOUT    = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    hdr_class_t hdr;
    logic [7:0] data;
    logic [6:0] index;
  } cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
    status_t    status;
    logic [7:0] reply_byte;
  } result_t;

  function automatic hdr_class_t classify_header(input logic [7:0] b);
    hdr_class_t c;
    if (b == HDR_EOT) begin
      c = HDR_CLASS_EOT;
    end else if (b == HDR_SOH) begin
      c = HDR_CLASS_SOH;
    end else begin
      c = HDR_CLASS_OTHER;
    end
    return c;
  endfunction

  // crc-16/xmodem, one byte, msb first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/xmodem_crc_packet_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          payload
// input     in         push / full        command, rx_byte
// result    out        empty / pop        kind, payload_byte, payload_index, status, reply_byte
//
// one item per cycle in and out while not stalled by full or empty; the front writes the
// command queue at the accepting edge, the back writes the result queue once it has room;
// the front tracks the byte position and header, the back keeps the crc and block numbers
// reset clears framing, crc and sets the expected block number to one
// full rises only when the two-entry command queue fills; a stalled result side backs up
// through the result queue and then the command queue

module xmodem_crc_packet_receiver
  import xcrc_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input item side
  input  logic       push,
  output logic       full,
  input  logic       command,
  input  logic [7:0] rx_byte,
  // result item side
  output logic       empty,
  input  logic       pop,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic [6:0] payload_index,
  output logic [2:0] status,
  output logic [7:0] reply_byte
);

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned RES_W = $bits(result_t);

  logic    accept;
  logic    q_push;
  cmd_t    q_wr_entry;
  cmd_t    q_rd_entry;
  logic    q_pop;
  logic    q_empty;
  logic    res_push;
  result_t res_wr;
  result_t res_rd;
  logic    res_full;

  // an item is taken whenever the command queue has room
  assign accept = push && !full;

  // front: framing and classification of each received byte or timeout
  xcrc_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (command),
    .rx_byte (rx_byte),
    .q_push  (q_push),
    .q_entry (q_wr_entry)
  );

  // short queue so front and back stall independently
  xcrc_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_entry),
    .pop     (q_pop),
    .rd_data (q_rd_entry),
    .full    (full),
    .empty   (q_empty)
  );

  // back: crc, block number checks and verdicts
  xcrc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_entry  (q_rd_entry),
    .q_pop    (q_pop),
    .out_full (res_full),
    .res_push (res_push),
    .result   (res_wr)
  );

  // result queue, head is shown on the result ports
  xcrc_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_wr),
    .pop     (pop),
    .rd_data (res_rd),
    .full    (res_full),
    .empty   (empty)
  );

  assign kind          = res_rd.kind;
  assign payload_byte  = res_rd.payload_byte;
  assign payload_index = res_rd.payload_index;
  assign status        = res_rd.status;
  assign reply_byte    = res_rd.reply_byte;

endmodule

`default_nettype wire

/* rtl/xcrc_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module xcrc_fifo
  import xcrc_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PTR_W+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/xcrc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module xcrc_front
  import xcrc_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       command,
  input  logic [7:0] rx_byte,
  output logic       q_push,
  output cmd_t       q_entry
);

  localparam int unsigned POS_W = $clog2(PAYLOAD_BYTES + 5);
  localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
  localparam logic [POS_W-1:0] POS_NUMBER = POS_W'(1);
  localparam logic [POS_W-1:0] POS_COMP   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(PAYLOAD_BYTES + 3);
  localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(PAYLOAD_BYTES + 4);

  logic [POS_W-1:0] pos, pos_next;
  logic [6:0]       pay_idx, pay_idx_next;
  hdr_class_t       hdr, hdr_next;
  logic             done, done_next;

  always_comb begin
    pos_next      = pos;
    pay_idx_next  = pay_idx;
    hdr_next      = hdr;
    done_next     = done;
    q_push        = 1'b0;
    q_entry.op    = OP_TIMEOUT;
    q_entry.hdr   = hdr;
    q_entry.data  = rx_byte;
    q_entry.index = pay_idx;
    if (accept && !done) begin
      if (command == CMD_TIMEOUT) begin
        q_push       = 1'b1;
        q_entry.op   = OP_TIMEOUT;
        pos_next     = POS_HEADER;
        pay_idx_next = '0;
        if (hdr == HDR_CLASS_EOT) begin
          done_next = 1'b1;
        end
      end else if (pos == POS_HEADER) begin
        hdr_next = classify_header(rx_byte);
        pos_next = POS_NUMBER;
      end else if (pos == POS_NUMBER) begin
        q_push     = 1'b1;
        q_entry.op = OP_NUMBER;
        pos_next   = POS_COMP;
      end else if (pos == POS_COMP) begin
        q_push     = 1'b1;
        q_entry.op = OP_COMPLEMENT;
        pos_next   = pos + POS_W'(1);
      end else if (pos < POS_CRC_HI) begin
        q_push       = 1'b1;
        q_entry.op   = OP_PAYLOAD;
        pos_next     = pos + POS_W'(1);
        pay_idx_next = pay_idx + 7'd1;
      end else if (pos == POS_CRC_HI) begin
        q_push     = 1'b1;
        q_entry.op = OP_CRC_HIGH;
        pos_next   = POS_CRC_LO;
      end else begin
        q_push       = 1'b1;
        q_entry.op   = OP_CRC_LOW;
        pos_next     = POS_HEADER;
        pay_idx_next = '0;
        if (hdr == HDR_CLASS_EOT) begin
          done_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= POS_HEADER;
      pay_idx <= '0;
      hdr     <= HDR_CLASS_OTHER;
      done    <= 1'b0;
    end else begin
      pos     <= pos_next;
      pay_idx <= pay_idx_next;
      hdr     <= hdr_next;
      done    <= done_next;
    end
  end

  // end of transfer is final
  a_done_sticky: assert property (@(posedge clk) disable iff (rst) done |=> done)
    else $error("transfer done flag dropped");

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_CRC_LO)
    else $error("byte position past end of packet");

endmodule

`default_nettype wire

/* rtl/xcrc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module xcrc_back
  import xcrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  cmd_t    q_entry,
  output logic    q_pop,
  input  logic    out_full,
  output logic    res_push,
  output result_t result
);

  logic [7:0]  number_byte;
  logic [7:0]  complement_byte;
  logic [7:0]  crc_high_received;
  logic [7:0]  expected_number;
  logic [15:0] running_crc;
  status_t     verdict;

  assign q_pop = !q_empty && !out_full;

  always_comb begin
    if (q_entry.op == OP_TIMEOUT) begin
      verdict = (q_entry.hdr == HDR_CLASS_EOT) ? ST_EOT : ST_TIMEOUT;
    end else if (q_entry.hdr == HDR_CLASS_EOT) begin
      verdict = ST_EOT;
    end else if (q_entry.hdr != HDR_CLASS_SOH) begin
      verdict = ST_BADHDR;
    end else if (number_byte != ~complement_byte) begin
      verdict = ST_BADCOMP;
    end else if (number_byte == expected_number - 8'd1) begin
      verdict = ST_DUP;
    end else if (number_byte != expected_number) begin
      verdict = ST_UNEXP;
    end else if ({crc_high_received, q_entry.data} != running_crc) begin
      verdict = ST_BADCRC;
    end else begin
      verdict = ST_OK;
    end
  end

  always_comb begin
    res_push = 1'b0;
    result   = '0;
    case (q_entry.op)
      OP_PAYLOAD: begin
        res_push             = q_pop;
        result.kind          = KIND_PAYLOAD;
        result.payload_byte  = q_entry.data;
        result.payload_index = q_entry.index;
      end
      OP_CRC_LOW, OP_TIMEOUT: begin
        res_push          = q_pop;
        result.kind       = KIND_VERDICT;
        result.status     = verdict;
        result.reply_byte = (verdict == ST_OK || verdict == ST_EOT) ? REPLY_ACK : REPLY_NAK;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_byte       <= '0;
      complement_byte   <= '0;
      crc_high_received <= '0;
      expected_number   <= 8'd1;
      running_crc       <= '0;
    end else if (q_pop) begin
      case (q_entry.op)
        OP_NUMBER:     number_byte       <= q_entry.data;
        OP_COMPLEMENT: complement_byte   <= q_entry.data;
        OP_PAYLOAD:    running_crc       <= crc_update(running_crc, q_entry.data);
        OP_CRC_HIGH:   crc_high_received <= q_entry.data;
        OP_CRC_LOW: begin
          running_crc <= '0;
          if (verdict == ST_OK) begin
            expected_number <= expected_number + 8'd1;
          end
        end
        OP_TIMEOUT:    running_crc       <= '0;
        default: begin
          running_crc <= running_crc;
        end
      endcase
    end
  end

  a_ok_advances: assert property (@(posedge clk) disable iff (rst)
      (q_pop && q_entry.op == OP_CRC_LOW && verdict == ST_OK)
      |=> expected_number == $past(expected_number) + 8'd1)
    else $error("expected block number did not advance on ok");

  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
      (q_pop && (q_entry.op == OP_TIMEOUT || q_entry.op == OP_CRC_LOW))
      |=> running_crc == 16'h0000)
    else $error("crc not restarted after verdict");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) res_push |-> !out_full)
    else $error("result pushed into full queue");

endmodule

`default_nettype wire

/* dv/tb_xmodem_crc_packet_receiver.sv */
`timescale 1ns / 1ps

module tb_xmodem_crc_packet_receiver;
  import xcrc_pkg::*;

  localparam int unsigned PAYLOAD      = PAYLOAD_BYTES_DEF;
  localparam int unsigned FRAME_LEN    = PAYLOAD + 5;
  localparam int unsigned ITEM_TARGET  = 1400;
  // margin through the block for stray results
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  // one entry of the stimulus queue; a pause entry holds the sender until all results are in
  typedef struct packed {
    bit         pause;
    command_t   cmd;
    logic [7:0] data;
  } stim_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic       command = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic       kind;
  logic [7:0] payload_byte;
  logic [6:0] payload_index;
  logic [2:0] status;
  logic [7:0] reply_byte;

  stim_t       pending[$];
  result_t     awaited_results[$];
  int unsigned total_items = 0;
  int unsigned accepted = 0;
  int unsigned payload_seen = 0;
  int unsigned verdicts_seen = 0;
  int unsigned verdict_tally[8];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned gap_pct;
  int unsigned stall_pct;

  // receiver state as the predictor sees it
  int unsigned frame_pos;
  logic [7:0]  hdr_seen;
  logic [7:0]  blk_num;
  logic [7:0]  blk_comp;
  logic [7:0]  crc_hi_rx;
  logic [7:0]  next_blk;
  logic [15:0] crc_acc;
  bit          xfer_over;

  xmodem_crc_packet_receiver dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command       (command),
    .rx_byte       (rx_byte),
    .empty         (empty),
    .pop           (pop),
    .kind          (kind),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .status        (status),
    .reply_byte    (reply_byte)
  );

  always #2 clk = ~clk;

  // crc-16/xmodem, shifted in bit by bit from the msb
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int k = 7; k >= 0; k--) begin
      fb  = acc[15] ^ b[k];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  // any header that is neither start of packet nor end of transfer
  function automatic logic [7:0] stray_header();
    logic [7:0] h;
    do begin
      h = 8'($urandom);
    end while (h == HDR_SOH || h == HDR_EOT);
    return h;
  endfunction

  // verdict: reply byte follows the status, framing restarts, eot closes the transfer
  task automatic post_verdict(input status_t s);
    result_t r;
    r.kind          = KIND_VERDICT;
    r.payload_byte  = 8'h00;
    r.payload_index = 7'd0;
    r.status        = s;
    r.reply_byte    = (s == ST_OK || s == ST_EOT) ? REPLY_ACK : REPLY_NAK;
    awaited_results.push_back(r);
    if (s == ST_EOT) xfer_over = 1'b1;
    frame_pos = 0;
    crc_acc   = 16'h0000;
  endtask

  // advance the receiver by one accepted item and queue what it should produce
  task automatic frame_event(input command_t cmd, input logic [7:0] b);
    result_t r;
    status_t s;
    if (xfer_over) return;
    if (cmd == CMD_TIMEOUT) begin
      // a timeout drops the packet; a pending eot header still counts as eot
      if (hdr_seen == HDR_EOT) post_verdict(ST_EOT);
      else post_verdict(ST_TIMEOUT);
      return;
    end
    if (frame_pos == 0) begin
      hdr_seen  = b;
      frame_pos = 1;
    end else if (frame_pos == 1) begin
      blk_num   = b;
      frame_pos = 2;
    end else if (frame_pos == 2) begin
      blk_comp  = b;
      frame_pos = 3;
    end else if (frame_pos < 3 + PAYLOAD) begin
      // payload goes out at once, before the crc is known
      crc_acc         = crc16_byte(crc_acc, b);
      r.kind          = KIND_PAYLOAD;
      r.payload_byte  = b;
      r.payload_index = 7'(frame_pos - 3);
      r.status        = ST_OK;
      r.reply_byte    = 8'h00;
      awaited_results.push_back(r);
      frame_pos++;
    end else if (frame_pos == 3 + PAYLOAD) begin
      crc_hi_rx = b;
      frame_pos++;
    end else begin
      // crc low byte closes the packet; checks in priority order
      if (hdr_seen == HDR_EOT) s = ST_EOT;
      else if (hdr_seen != HDR_SOH) s = ST_BADHDR;
      else if (blk_num != ~blk_comp) s = ST_BADCOMP;
      else if (blk_num == 8'(next_blk - 8'd1)) s = ST_DUP;
      else if (blk_num != next_blk) s = ST_UNEXP;
      else if (crc_hi_rx != crc_acc[15:8] || b != crc_acc[7:0]) s = ST_BADCRC;
      else s = ST_OK;
      if (s == ST_OK) next_blk = next_blk + 8'd1;
      post_verdict(s);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    stim_t s;
    s.pause = 1'b0;
    s.cmd   = CMD_BYTE;
    s.data  = b;
    pending.push_back(s);
    total_items++;
  endtask

  task automatic queue_timeout();
    stim_t s;
    s.pause = 1'b0;
    s.cmd   = CMD_TIMEOUT;
    s.data  = 8'($urandom);
    pending.push_back(s);
    total_items++;
  endtask

  task automatic queue_pause();
    stim_t s;
    s.pause = 1'b1;
    s.cmd   = CMD_BYTE;
    s.data  = 8'h00;
    pending.push_back(s);
  endtask

  // one frame with random payload; keep below the frame length cuts it off with a timeout
  task automatic queue_packet(input logic [7:0] hdr, input logic [7:0] num,
                              input logic [7:0] comp, input bit spoil_crc,
                              input int unsigned keep, input int pause_after);
    logic [7:0]  frame[FRAME_LEN];
    logic [15:0] c;
    c = 16'h0000;
    frame[0] = hdr;
    frame[1] = num;
    frame[2] = comp;
    for (int i = 0; i < PAYLOAD; i++) begin
      frame[3 + i] = 8'($urandom);
      c = crc16_byte(c, frame[3 + i]);
    end
    if (spoil_crc) c = c ^ 16'($urandom_range(1, 16'hffff));
    frame[PAYLOAD + 3] = c[15:8];
    frame[PAYLOAD + 4] = c[7:0];
    for (int i = 0; i < keep; i++) begin
      queue_byte(frame[i]);
      if (i == pause_after) queue_pause();
    end
    if (keep < FRAME_LEN) queue_timeout();
  endtask

  // idling profile by progress: slow receiver, then slow sender, then full speed
  always @* begin
    if (accepted < total_items / 3) begin
      gap_pct   = 9;
      stall_pct = 87;
    end else if (accepted < 2 * (total_items / 3)) begin
      gap_pct   = 87;
      stall_pct = 9;
    end else begin
      gap_pct   = 0;
      stall_pct = 0;
    end
  end

  // driver: predicts on acceptance, then offers the next item or idles
  always @(posedge clk) begin : driver
    stim_t nxt;
    bit    taken;
    if (rst) begin
      push      <= 1'b0;
      frame_pos =  0;
      hdr_seen  =  8'h00;
      blk_num   =  8'h00;
      blk_comp  =  8'h00;
      crc_hi_rx =  8'h00;
      next_blk  =  8'h01;
      crc_acc   =  16'h0000;
      xfer_over =  1'b0;
    end else begin
      taken = push && !full;
      if (taken) begin
        frame_event(command_t'(command), rx_byte);
        accepted++;
      end
      // an offered item stays on the bus until taken
      if (!push || taken) begin
        // a pause entry is released once every awaited result has come back
        while (pending.size() > 0 && pending[0].pause && awaited_results.size() == 0)
          void'(pending.pop_front());
        if (pending.size() == 0 || pending[0].pause || $urandom_range(99) < gap_pct) begin
          push <= 1'b0;
        end else begin
          nxt = pending.pop_front();
          push    <= 1'b1;
          command <= nxt.cmd;
          rx_byte <= nxt.data;
        end
      end
    end
  end

  // monitor: every popped result against the oldest awaited one
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h idx %0d st %0d rep %02h",
                                    kind, payload_byte, payload_index, status, reply_byte));
        end else begin
          want = awaited_results.pop_front();
          if (kind !== want.kind || payload_byte !== want.payload_byte ||
              payload_index !== want.payload_index || status !== want.status ||
              reply_byte !== want.reply_byte) begin
            report_mismatch($sformatf(
              "got kind %0d byte %02h idx %0d st %0d rep %02h, want %0d %02h %0d %0d %02h",
              kind, payload_byte, payload_index, status, reply_byte, want.kind,
              want.payload_byte, want.payload_index, want.status, want.reply_byte));
          end
          if (want.kind == KIND_PAYLOAD) begin
            payload_seen++;
          end else begin
            verdicts_seen++;
            verdict_tally[want.status]++;
          end
        end
      end
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0]  hdr;
    logic [7:0]  num;
    logic [7:0]  comp;
    logic [7:0]  gen_next;
    bit          spoil;
    bit          clean;
    bit          lead;
    int unsigned pick;
    int unsigned keep;
    int unsigned n;

    // directed: timeout with nothing received
    queue_timeout();
    // back to back timeout, then header alone
    queue_timeout();
    queue_byte(HDR_SOH);
    queue_timeout();
    // odd header, extreme number bytes and payload extremes, cut short
    queue_byte(8'h00);
    queue_byte(8'hff);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(8'hff);
    queue_byte(8'h80);
    queue_byte(8'h7f);
    queue_timeout();
    // well formed start of block one, cut short
    queue_byte(HDR_SOH);
    queue_byte(8'h01);
    queue_byte(8'hfe);
    queue_byte(8'h55);
    queue_byte(8'haa);
    queue_timeout();
    queue_pause();

    // random: mostly whole frames with occasional faults, some noise
    gen_next = 8'h01;
    lead     = 1'b1;
    while (pending.size() < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        queue_timeout();
      end else if (pick < 12) begin
        queue_byte(stray_header());
        n = $urandom_range(0, 6);
        repeat (n) queue_byte(8'($urandom));
        queue_timeout();
      end else begin
        clean = 1'b1;
        hdr   = HDR_SOH;
        num   = gen_next;
        if ($urandom_range(99) < 12) begin
          hdr   = stray_header();
          clean = 1'b0;
        end
        pick = $urandom_range(99);
        if (pick < 12) begin
          // repeat of the last good block
          num   = gen_next - 8'd1;
          clean = 1'b0;
        end else if (pick < 30) begin
          do begin
            num = 8'($urandom);
          end while (num == gen_next || num == 8'(gen_next - 8'd1));
          clean = 1'b0;
        end
        comp = ~num;
        if ($urandom_range(99) < 12) begin
          comp  = comp ^ 8'($urandom_range(1, 255));
          clean = 1'b0;
        end
        spoil = ($urandom_range(99) < 15);
        if (spoil) clean = 1'b0;
        keep = FRAME_LEN;
        if ($urandom_range(99) < 12) begin
          keep  = $urandom_range(1, FRAME_LEN - 1);
          clean = 1'b0;
        end
        // first frame also pauses the sender in mid payload
        queue_packet(hdr, num, comp, spoil, keep, lead ? 60 : -1);
        lead = 1'b0;
        if (clean) gen_next = gen_next + 8'd1;
        if ($urandom_range(99) < 15) queue_pause();
      end
    end

    // end of transfer, by a whole eot frame or by a timeout after the eot header
    if ($urandom_range(1) == 1) begin
      queue_packet(HDR_EOT, 8'($urandom), 8'($urandom), 1'b0, FRAME_LEN, -1);
    end else begin
      queue_byte(HDR_EOT);
      n = $urandom_range(0, 8);
      repeat (n) queue_byte(8'($urandom));
      queue_timeout();
    end
    // anything after eot must be swallowed
    repeat (6) begin
      if ($urandom_range(1) == 1) queue_timeout();
      else queue_byte(8'($urandom));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (accepted != total_items) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d items in, %0d payload bytes and %0d verdicts checked, %0d errors",
             accepted, payload_seen, verdicts_seen, errors);
    $display("verdicts ok %0d timeout %0d eot %0d comp %0d dup %0d unexp %0d crc %0d hdr %0d",
             verdict_tally[ST_OK], verdict_tally[ST_TIMEOUT], verdict_tally[ST_EOT],
             verdict_tally[ST_BADCOMP], verdict_tally[ST_DUP], verdict_tally[ST_UNEXP],
             verdict_tally[ST_BADCRC], verdict_tally[ST_BADHDR]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
